FILE: design/prrm_pkg.sv
package prrm_pkg;

   // operation codes
   localparam logic [1:0] OP_POST  = 2'd0;
   localparam logic [1:0] OP_MATCH = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_REJECT   = 2'd3;

   // owner resource that marks an I2C request
   localparam logic [15:0] OWNER_I2C = 16'hFFFF;

   // one table entry
   typedef struct packed {
      logic [7:0]  addr;
      logic [5:0]  netfn;
      logic [7:0]  cmd;
      logic [7:0]  seq;
      logic [15:0] owner;
   } entry_type;

   // captured request, broadcast to every cell
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  addr;
      logic [5:0]  netfn;
      logic [7:0]  cmd;
      logic [7:0]  seq;
      logic [15:0] owner;
      logic        want_i2c;
      logic        well_formed;
   } key_type;

   // search wave handed from cell to cell, one cell per cycle
   typedef struct packed {
      logic        active;
      logic        seen_seq;
      logic        seen_any;
      logic [15:0] owner_seq;
      logic [15:0] owner_any;
   } wave_type;

   // per-cycle commands from the sequencer to the row
   typedef struct packed {
      logic post;
      logic wave_start;
      logic kill_match;
      logic use_seq;
      logic kill_flush;
      logic sort_even;
      logic sort_odd;
   } ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAVE,
      ST_SORT,
      ST_RESPOND
   } state_type;

endpackage

FILE: design/prrm_cell.sv
module prrm_cell #(
   parameter bit ODD_POSITION = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  prrm_pkg::ctrl_type  ctrl,
   input  prrm_pkg::key_type   key,
   input  logic                lower_valid,
   input  logic                upper_valid,
   input  prrm_pkg::entry_type upper_entry,
   input  prrm_pkg::wave_type  wave_in,
   output logic                valid_out,
   output prrm_pkg::entry_type entry_out,
   output prrm_pkg::wave_type  wave_out
);
   import prrm_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   wave_type  wave_ff, wave_in_next;
   logic      pick_seq_ff, pick_seq_in;
   logic      pick_any_ff, pick_any_in;
   logic      is_i2c, qual, qual_seq;
   logic      left_now, right_now;

   // local compare against the broadcast response
   always_comb begin
      is_i2c   = (entry_ff.owner == OWNER_I2C);
      qual     = valid_ff && (is_i2c == key.want_i2c) && (entry_ff.addr == key.addr) &&
                 (entry_ff.netfn == {key.netfn[5:1], 1'b0}) && (entry_ff.cmd == key.cmd);
      qual_seq = qual && (entry_ff.seq == key.seq);
   end

   // role in this round of the odd-even compaction
   always_comb begin
      left_now  = (ctrl.sort_even && !ODD_POSITION) || (ctrl.sort_odd && ODD_POSITION);
      right_now = (ctrl.sort_even && ODD_POSITION) || (ctrl.sort_odd && !ODD_POSITION);
   end

   // entry update: append, removal, neighbor exchange
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.post && !valid_ff && lower_valid) begin
         valid_in       = 1'b1;
         entry_in.addr  = key.addr;
         entry_in.netfn = key.netfn;
         entry_in.cmd   = key.cmd;
         entry_in.seq   = key.seq;
         entry_in.owner = key.owner;
      end
      if (ctrl.kill_match && valid_ff && (ctrl.use_seq ? pick_seq_ff : pick_any_ff)) begin
         valid_in = 1'b0;
      end
      if (ctrl.kill_flush && valid_ff && (entry_ff.owner == key.owner)) begin
         valid_in = 1'b0;
      end
      if (left_now && !valid_ff && upper_valid) begin
         valid_in = 1'b1;
         entry_in = upper_entry;
      end
      if (right_now && valid_ff && !lower_valid) begin
         valid_in = 1'b0;
      end
   end

   // search wave: first sequence hit and first plain hit, oldest first
   always_comb begin
      wave_in_next          = wave_in;
      wave_in_next.seen_seq = wave_in.seen_seq || qual_seq;
      wave_in_next.seen_any = wave_in.seen_any || qual;
      if (qual_seq && !wave_in.seen_seq) begin
         wave_in_next.owner_seq = entry_ff.owner;
      end
      if (qual && !wave_in.seen_any) begin
         wave_in_next.owner_any = entry_ff.owner;
      end
      pick_seq_in = wave_in.active ? (qual_seq && !wave_in.seen_seq) : pick_seq_ff;
      pick_any_in = wave_in.active ? (qual && !wave_in.seen_any) : pick_any_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      pick_seq_ff <= pick_seq_in;
      pick_any_ff <= pick_any_in;
   end

   assign valid_out = valid_ff;
   assign entry_out = entry_ff;
   assign wave_out  = wave_ff;

endmodule

FILE: design/prrm_seq.sv
module prrm_seq #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  prrm_pkg::key_type  key,
   input  logic               table_full,
   input  prrm_pkg::wave_type wave_top,
   output logic               busy,
   output prrm_pkg::ctrl_type ctrl,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_owner
);
   import prrm_pkg::*;

   localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] SORT_LAST = CNT_W'(DEPTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       status_ff, status_in;
   logic [15:0]      owner_ff, owner_in;
   logic             found;

   assign found = wave_top.seen_seq || wave_top.seen_any;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (key.op)
               OP_MATCH: state_in = ST_WAVE;
               OP_FLUSH: state_in = ST_SORT;
               default:  state_in = ST_RESPOND;
            endcase
         end
         ST_WAVE: begin
            if (wave_top.active) state_in = found ? ST_SORT : ST_RESPOND;
         end
         ST_SORT: begin
            if (count_ff == SORT_LAST) state_in = ST_RESPOND;
         end
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and result bookkeeping
   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = status_ff;
      owner_in  = owner_ff;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            status_in = STATUS_OK;
            owner_in  = '0;
            count_in  = '0;
            case (key.op)
               OP_POST: begin
                  if (!key.well_formed) begin
                     status_in = STATUS_REJECT;
                  end else if (table_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ctrl.post = 1'b1;
                  end
               end
               OP_MATCH: ctrl.wave_start = 1'b1;
               OP_FLUSH: ctrl.kill_flush = 1'b1;
               default:  ;
            endcase
         end
         ST_WAVE: begin
            if (wave_top.active) begin
               if (found) begin
                  ctrl.kill_match = 1'b1;
                  ctrl.use_seq    = wave_top.seen_seq;
                  owner_in = wave_top.seen_seq ? wave_top.owner_seq : wave_top.owner_any;
               end else begin
                  status_in = STATUS_NO_MATCH;
               end
            end
         end
         ST_SORT: begin
            ctrl.sort_even = !count_ff[0];
            ctrl.sort_odd  = count_ff[0];
            count_in       = count_ff + CNT_W'(1);
         end
         ST_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      status_ff <= status_in;
      owner_ff  <= owner_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_status = status_ff;
   assign rsp_owner  = owner_ff;

endmodule

FILE: design/pending_request_response_matcher_core.sv
// Path from accepted start to the rsp_valid cycle: post and the unused op go from EXEC
// straight to RESPOND; flush runs the compaction; match runs the search wave, then on a hit
// the compaction (search wave crosses the row one cell per cycle, then the compaction rounds).
// One operation at a time: busy is high until the response cycle ends, so the next
// start is taken in the cycle after rsp_valid. The receiver cannot stall the response.
// Synchronous active-high reset empties the table and returns the sequencer to idle.
module pending_request_response_matcher_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_bus_addr,
   input  logic [7:0]         req_netfn_lun,
   input  logic [7:0]         req_cmd_code,
   input  logic [7:0]         req_seq_number,
   input  logic signed [15:0] req_owner,
   input  logic               req_want_i2c,
   input  logic               req_well_formed,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_matched_owner
);
   import prrm_pkg::*;

   key_type                key_ff, key_in;
   logic                   accept;
   ctrl_type               ctrl;
   logic [TABLE_DEPTH-1:0] valid_row;
   logic [TABLE_DEPTH-1:0] lower_valid;
   logic [TABLE_DEPTH-1:0] upper_valid;
   entry_type              entry_row [TABLE_DEPTH];
   entry_type              upper_entry [TABLE_DEPTH];
   wave_type               wave_row [TABLE_DEPTH+1];
   wave_type               wave_first;
   logic [15:0]            owner_out;

   assign accept = start && !busy;

   // capture the request on transfer
   always_comb begin
      key_in = key_ff;
      if (accept) begin
         key_in.op          = req_op;
         key_in.addr        = req_bus_addr;
         key_in.netfn       = req_netfn_lun[7:2];
         key_in.cmd         = req_cmd_code;
         key_in.seq         = req_seq_number;
         key_in.owner       = req_owner;
         key_in.want_i2c    = req_want_i2c;
         key_in.well_formed = req_well_formed;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // wave entry point
   always_comb begin
      wave_first        = '0;
      wave_first.active = ctrl.wave_start;
   end

   assign wave_row[0] = wave_first;

   // row of cells, slot 0 holds the oldest entry
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_bottom
         assign lower_valid[k] = 1'b1;
      end else begin : g_lower
         assign lower_valid[k] = valid_row[k-1];
      end
      if (k == TABLE_DEPTH - 1) begin : g_top
         assign upper_valid[k] = 1'b0;
         assign upper_entry[k] = '0;
      end else begin : g_upper
         assign upper_valid[k] = valid_row[k+1];
         assign upper_entry[k] = entry_row[k+1];
      end

      prrm_cell #(
         .ODD_POSITION ((k % 2) == 1)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key_ff),
         .lower_valid (lower_valid[k]),
         .upper_valid (upper_valid[k]),
         .upper_entry (upper_entry[k]),
         .wave_in     (wave_row[k]),
         .valid_out   (valid_row[k]),
         .entry_out   (entry_row[k]),
         .wave_out    (wave_row[k+1])
      );
   end

   prrm_seq #(
      .DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .key        (key_ff),
      .table_full (valid_row[TABLE_DEPTH-1]),
      .wave_top   (wave_row[TABLE_DEPTH]),
      .busy       (busy),
      .ctrl       (ctrl),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_owner  (owner_out)
   );

   assign rsp_matched_owner = owner_out;

   // checks
   logic [TABLE_DEPTH-1:0] prefix_check;
   assign prefix_check = valid_row & (valid_row + TABLE_DEPTH'(1));

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside an operation");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid) else $error("no work after request transfer");

   a_packed_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (prefix_check == '0)) else $error("table not compacted at response");

   a_wave_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      wave_row[TABLE_DEPTH].active |-> busy) else $error("search wave while idle");

endmodule
